>>> design/spq_pkg.sv
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned PrioW    = 8;
  localparam int unsigned InfoW    = 8;
  localparam int unsigned CountW   = 5;

  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [InfoW-1:0] info;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

>>> design/spq_cell.sv
// one slot of the sorted chain: holds an entry, shifts toward head or tail
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  spq_pkg::entry_t    new_entry_i,
  input  logic               left_disp_i,
  input  spq_pkg::entry_t    left_entry_i,
  input  spq_pkg::entry_t    right_entry_i,
  output spq_pkg::entry_t    entry_o,
  output logic               disp_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // empty slot or strictly larger priority makes room for the new entry
  assign disp_o = !occ_i || (entry_q.prio > new_entry_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end else if (ctrl_i.ins && disp_o) begin
      entry_d = left_disp_i ? left_entry_i : new_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> design/sorted_priority_queue_unit.sv
// sorted priority queue: chain of entry cells, count register and result register
// the result beat of an accepted input beat is registered and presented in the next cycle
// throughput: one add or remove per cycle while each result is taken, every cell compares and shifts in parallel
// a new beat is taken while a result waits only if that result leaves in the same cycle
// reset clears the entry count and the result valid flag; stored entries are not cleared
// entries beyond the count are never read, so no clearing pass is needed
module sorted_priority_queue_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [spq_pkg::PrioW-1:0] entry_prio_i,
  input  logic [spq_pkg::InfoW-1:0] entry_info_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [spq_pkg::PrioW-1:0] out_prio_o,
  output logic [spq_pkg::InfoW-1:0] out_info_o,
  output logic [spq_pkg::CountW-1:0] count_o,
  output logic                      is_empty_o,
  output logic                      is_full_o
);

  localparam int unsigned N = spq_pkg::Capacity;

  // queue occupancy
  logic [spq_pkg::CntW-1:0] count_q, count_d;
  logic                     full, empty;

  // result register
  logic                      out_valid_q, out_valid_d;
  spq_pkg::status_e          status_q, status_d;
  spq_pkg::entry_t           res_q, res_d;

  logic                      in_fire;
  logic                      do_ins, do_rem;
  spq_pkg::cell_ctrl_t       ctrl;
  spq_pkg::entry_t           new_entry;

  // chain wiring
  spq_pkg::entry_t           cell_entry [N];
  logic [N-1:0]              cell_disp;
  logic [N-1:0]              cell_occ;

  assign full       = (count_q == spq_pkg::CntW'(N));
  assign empty      = (count_q == '0);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // accepted op that actually changes the store
  assign do_ins = in_fire && (action_i == spq_pkg::ACT_ADD) && !full;
  assign do_rem = in_fire && (action_i == spq_pkg::ACT_REMOVE) && !empty;

  assign ctrl.ins = do_ins;
  assign ctrl.rem = do_rem;

  assign new_entry.prio = entry_prio_i;
  assign new_entry.info = entry_info_i;

  // cells below the count hold live entries, head is cell zero
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left_e, right_e;
    logic            left_d;

    assign cell_occ[i] = (count_q > spq_pkg::CntW'(i));

    if (i == 0) begin : g_head
      assign left_d = 1'b0;
      assign left_e = new_entry;
    end else begin : g_body
      assign left_d = cell_disp[i-1];
      assign left_e = cell_entry[i-1];
    end

    // tail slot takes the input entry on remove; it then lies beyond the count
    if (i == N - 1) begin : g_tail
      assign right_e = new_entry;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (cell_occ[i]),
      .new_entry_i  (new_entry),
      .left_disp_i  (left_d),
      .left_entry_i (left_e),
      .right_entry_i(right_e),
      .entry_o      (cell_entry[i]),
      .disp_o       (cell_disp[i])
    );
  end

  // count update and result formation
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    res_d       = res_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      unique case (action_i)
        spq_pkg::ACT_ADD: begin
          if (full) begin
            status_d = spq_pkg::ST_FULL;
          end else begin
            status_d = spq_pkg::ST_OK;
            count_d  = count_q + spq_pkg::CntW'(1);
          end
        end
        spq_pkg::ACT_REMOVE: begin
          if (empty) begin
            status_d = spq_pkg::ST_EMPTY;
          end else begin
            status_d = spq_pkg::ST_OK;
            res_d    = cell_entry[0];
            count_d  = count_q - spq_pkg::CntW'(1);
          end
        end
        default: status_d = spq_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the result beat, no reset needed
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_q    <= res_d;
  end

  // count, empty and full reflect the state after the last accepted op
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_prio_o  = res_q.prio;
  assign out_info_o  = res_q.info;
  assign count_o     = spq_pkg::CountW'(count_q);
  assign is_empty_o  = empty;
  assign is_full_o   = full;

  // occupancy never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CntW'(N))
    else $error("entry count above capacity");

  // a successful add grows the count by one
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> count_q == $past(count_q) + spq_pkg::CntW'(1))
    else $error("add did not grow count");

  // head pair stays in priority order
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= spq_pkg::CntW'(2) |-> cell_entry[0].prio <= cell_entry[1].prio)
    else $error("head entries out of order");

  // remove on an empty queue is flagged
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && action_i == spq_pkg::ACT_REMOVE && empty)
      |=> out_valid_q && status_q == spq_pkg::ST_EMPTY)
    else $error("empty remove not flagged");

endmodule
